// ----- rtl/fpmm_pkg.sv -----
// ----------------------------------------------------------------------------
// fpmm_pkg
// Types and constants shared by the floating-point min/max block.
// ----------------------------------------------------------------------------
package fpmm_pkg;

	localparam logic [63:0] S_QNAN = 64'h0000_0000_7fc0_0000;
	localparam logic [63:0] S_SNAN = 64'h0000_0000_7f80_0001;
	localparam logic [63:0] D_QNAN = 64'h7ff8_0000_0000_0000;
	localparam logic [63:0] D_SNAN = 64'h7ff0_0000_0000_0001;

	typedef struct packed {
		logic        req_type;
		logic        is_double;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
	} req_t;

	typedef struct packed {
		logic [63:0] result_bits;
		logic        invalid_flag;
	} rsp_t;

endpackage

// ----- rtl/fpmm_core.sv -----
// ----------------------------------------------------------------------------
// fpmm_core
// Combinational min/max select with zero, NaN and compare handling.
// ----------------------------------------------------------------------------
module fpmm_core (
	input  fpmm_pkg::req_t req,
	output fpmm_pkg::rsp_t rsp
);

	logic [63:0] a, b, r;
	logic        sa, sb, az, bz, an, bn, as_, bs_, lt_mag, eq, le;

	always_comb begin
		if (req.is_double) begin
			a   = req.operand_a;
			b   = req.operand_b;
			sa  = a[63];
			sb  = b[63];
			az  = (a[62:0] == 63'd0);
			bz  = (b[62:0] == 63'd0);
			an  = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
			bn  = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
			as_ = an && !a[51];
			bs_ = bn && !b[51];
		end else begin
			a   = {32'd0, req.operand_a[31:0]};
			b   = {32'd0, req.operand_b[31:0]};
			sa  = a[31];
			sb  = b[31];
			az  = (a[30:0] == 31'd0);
			bz  = (b[30:0] == 31'd0);
			an  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
			bn  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
			as_ = an && !a[22];
			bs_ = bn && !b[22];
		end
		lt_mag = (a < b);
		eq     = (a == b);
		// ordered quiet a <= b
		if (an || bn)
			le = 1'b0;
		else if (sa != sb)
			le = sa || (az && bz);
		else
			le = eq || (sa != lt_mag);

		if (az && bz) begin
			if (req.req_type) r = (!sa && sb) ? a : b;
			else              r = (sa && !sb) ? a : b;
		end else if (an && bn) begin
			if (as_ || bs_) r = req.is_double ? fpmm_pkg::D_SNAN : fpmm_pkg::S_SNAN;
			else            r = req.is_double ? fpmm_pkg::D_QNAN : fpmm_pkg::S_QNAN;
		end else if (bn) begin
			r = a;
		end else if (an) begin
			r = b;
		end else if (req.req_type) begin
			r = le ? b : a;
		end else begin
			r = le ? a : b;
		end
		rsp.result_bits  = r;
		rsp.invalid_flag = as_ || bs_;
	end

endmodule

// ----- rtl/fp_min_max.sv -----
// ----------------------------------------------------------------------------
// fp_min_max
// Floating-point minimum/maximum, binary32 and binary64, valid/ready channels.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; the request is held in the
// input register while the combinational core computes the result.
// Throughput: one transaction per cycle while out_ready is not held low; the
// compare/select between the two registers is combinational.
// Reset clears only the two valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module fp_min_max (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fpmm_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output fpmm_pkg::rsp_t out_data
);

	fpmm_pkg::req_t req_s1;
	logic           vld_s1;
	fpmm_pkg::rsp_t rsp_c, rsp_s2;
	logic           vld_s2;
	logic           adv_s2;

	// Stage 2 takes a new result when empty or being drained this cycle.
	assign adv_s2   = !vld_s2 || out_ready;
	// Stage 1 moves whenever stage 2 can take it.
	assign in_ready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (adv_s2)   vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) req_s1 <= in_data;
		if (adv_s2 && vld_s1)     rsp_s2 <= rsp_c;
	end

	fpmm_core u_core (
		.req(req_s1),
		.rsp(rsp_c)
	);

	assign out_valid = vld_s2;
	assign out_data  = rsp_s2;

	// A held result must not change while it waits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	// Stage 1 content cannot be dropped while stage 2 stalls.
	a_nodrop: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv_s2 |=> vld_s1 && $stable(req_s1))
		else $error("stage 1 lost");
	// Input ready only ever falls with both stages full.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s1 && vld_s2 && !out_ready)
		else $error("ready low without backpressure");

endmodule
